// ===== design/fcs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcs_pkg: shared types and constants of the page flash command splitter
// Field widths, command and status codes, register map and the structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fcs_pkg;

  // Field widths
  localparam int unsigned ADDR_BITS      = 24;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned LEN_W          = 24;
  localparam int unsigned KIND_W         = 3;
  localparam int unsigned SEG_W          = 12;
  localparam int unsigned PAGE_IDX_W     = 14;
  localparam int unsigned STAT_W         = 2;
  localparam int unsigned PSZ_W          = 12;
  localparam int unsigned SHIFT_W        = 4;
  localparam int unsigned CHIP_W         = 25;
  localparam int unsigned DIV_CNT_W      = $clog2(LEN_W + 1);

  // Limits
  localparam int unsigned MAX_SPAN_PAGES = 32;
  localparam logic [PSZ_W-1:0] PSZ_MAX   = PSZ_W'(2048);
  localparam logic [PSZ_W-1:0] PSZ_MIN   = PSZ_W'(1);
  localparam logic [ADDR_BITS-1:0] ADDR_LOW_MASK = ADDR_BITS'(32'h0000_00FF);

  // Register map (word index)
  localparam int unsigned REG_IDX_W      = 2;
  localparam int unsigned PADDR_W        = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_PAGE_BYTES = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAGE_SHIFT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHIP_BYTES = 2'd2;
  localparam logic [PSZ_W-1:0]   PAGE_BYTES_RST = PSZ_W'(528);
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = SHIFT_W'(10);
  localparam logic [CHIP_W-1:0]  CHIP_BYTES_RST = CHIP_W'(2162688);

  // Operations
  localparam logic [OP_W-1:0] OP_READ   = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PROGRAM = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ERASE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BEYOND   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISALIGN = 2'd2;
  localparam logic [STAT_W-1:0] STAT_SPAN     = 2'd3;

  // Result selection for the datapath
  localparam int unsigned EMIT_SEL_W = 2;
  localparam logic [EMIT_SEL_W-1:0] EMIT_FLAG = 2'd0;  // empty or error beat
  localparam logic [EMIT_SEL_W-1:0] EMIT_LOAD = 2'd1;  // page to buffer
  localparam logic [EMIT_SEL_W-1:0] EMIT_MAIN = 2'd2;  // read, program or erase

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [LEN_W-1:0] start_address;
    logic [LEN_W-1:0] byte_length;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0]     command_kind;
    logic [ADDR_BITS-1:0]  device_address;
    logic [SEG_W-1:0]      segment_bytes;
    logic [PAGE_IDX_W-1:0] page_index;
    logic [STAT_W-1:0]     status;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic [PSZ_W-1:0]   page_bytes;
    logic [SHIFT_W-1:0] page_shift;
    logic [CHIP_W-1:0]  chip_bytes;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic                  load;       // capture the request
    logic                  div_go;     // launch a division
    logic                  div_len;    // divide the length, else the address
    logic                  take_page;  // keep quotient and remainder as page, offset
    logic                  emit;       // register a result beat
    logic [EMIT_SEL_W-1:0] emit_sel;
    logic [STAT_W-1:0]     status;
    logic                  step;       // advance to the next page
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty_req;
    logic over_chip;
    logic is_write;
    logic is_erase;
    logic div_done;
    logic div_rem_zero;
    logic off_zero;
    logic len_zero;
    logic span_over;
    logic partial;
    logic final_seg;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/fcs_div.sv =====
// ----------------------------------------------------------------------------
// fcs_div: iterative restoring divider
// Divides a byte address or length by the page size, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fcs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [fcs_pkg::LEN_W-1:0]   dividend_i,
  input  logic [fcs_pkg::PSZ_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [fcs_pkg::LEN_W-1:0]   quotient_o,
  output logic [fcs_pkg::PSZ_W-1:0]   remainder_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [fcs_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [fcs_pkg::LEN_W-1:0]         quo_q, quo_d;
  logic [fcs_pkg::PSZ_W-1:0]         rem_q, rem_d;
  logic [fcs_pkg::PSZ_W:0]           trial;
  logic [fcs_pkg::PSZ_W:0]           diff;
  logic                              fits;

  // Bring down the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[fcs_pkg::LEN_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (go_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = fcs_pkg::DIV_CNT_W'(fcs_pkg::LEN_W);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[fcs_pkg::LEN_W-2:0], fits};
      rem_d = fits ? diff[fcs_pkg::PSZ_W-1:0] : trial[fcs_pkg::PSZ_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == fcs_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ===== design/fcs_dp.sv =====
// ----------------------------------------------------------------------------
// fcs_dp: request datapath
// Holds the request, page, offset and remaining count, runs the divider,
// forms device addresses and registers each result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fcs_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fcs_pkg::cfg_t    cfg_i,
  input  fcs_pkg::req_t    req_i,
  input  fcs_pkg::cmd_t    cmd_i,
  output fcs_pkg::sts_t    sts_o,
  output logic             res_strobe_o,
  output fcs_pkg::res_t    res_o
);

  logic [fcs_pkg::PSZ_W-1:0]     psz;
  logic [fcs_pkg::OP_W-1:0]      op_q;
  logic [fcs_pkg::LEN_W-1:0]     start_q;
  logic [fcs_pkg::LEN_W-1:0]     len_q;
  logic [fcs_pkg::LEN_W-1:0]     page_q;
  logic [fcs_pkg::PSZ_W-1:0]     offset_q;
  logic [fcs_pkg::LEN_W-1:0]     remaining_q;
  logic                          strobe_q;
  fcs_pkg::res_t                 res_q, res_d;

  logic                          div_done;
  logic [fcs_pkg::LEN_W-1:0]     div_quo;
  logic [fcs_pkg::PSZ_W-1:0]     div_rem;
  logic [fcs_pkg::LEN_W-1:0]     div_operand;

  logic [fcs_pkg::CHIP_W-1:0]    req_end;
  logic [fcs_pkg::CHIP_W-1:0]    span_need;
  logic [fcs_pkg::CHIP_W-1:0]    span_lim;
  logic [fcs_pkg::PSZ_W-1:0]     avail;
  logic                          fits_page;
  logic [fcs_pkg::SEG_W-1:0]     seg;
  logic [fcs_pkg::ADDR_BITS-1:0] addr_base;
  logic [fcs_pkg::ADDR_BITS-1:0] addr_main;
  logic [fcs_pkg::ADDR_BITS-1:0] addr_page;

  // Clamp the page size into 1 .. 2048
  always_comb begin
    if (cfg_i.page_bytes == '0) begin
      psz = fcs_pkg::PSZ_MIN;
    end else if (cfg_i.page_bytes > fcs_pkg::PSZ_MAX) begin
      psz = fcs_pkg::PSZ_MAX;
    end else begin
      psz = cfg_i.page_bytes;
    end
  end

  assign div_operand = cmd_i.div_len ? len_q : start_q;

  fcs_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (cmd_i.div_go),
    .dividend_i  (div_operand),
    .divisor_i   (psz),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Range and span checks
  assign req_end   = {1'b0, start_q} + {1'b0, len_q};
  assign span_need = fcs_pkg::CHIP_W'(offset_q) + {1'b0, len_q};
  assign span_lim  = fcs_pkg::CHIP_W'(psz) * fcs_pkg::CHIP_W'(fcs_pkg::MAX_SPAN_PAGES);

  // Segment within the current page
  assign avail     = psz - offset_q;
  assign fits_page = remaining_q <= fcs_pkg::LEN_W'(avail);
  assign seg       = fits_page ? remaining_q[fcs_pkg::SEG_W-1:0] : avail;

  // Device address: page shifted into place, plus offset
  assign addr_base = page_q << cfg_i.page_shift;
  assign addr_main = addr_base + fcs_pkg::ADDR_BITS'(offset_q);
  assign addr_page = addr_base & ~fcs_pkg::ADDR_LOW_MASK;

  always_comb begin
    sts_o.empty_req    = (op_q == fcs_pkg::OP_UNUSED) ||
                         ((len_q == '0) && (op_q != fcs_pkg::OP_ERASE));
    sts_o.over_chip    = req_end > cfg_i.chip_bytes;
    sts_o.is_write     = op_q == fcs_pkg::OP_WRITE;
    sts_o.is_erase     = op_q == fcs_pkg::OP_ERASE;
    sts_o.div_done     = div_done;
    sts_o.div_rem_zero = div_rem == '0;
    sts_o.off_zero     = offset_q == '0;
    sts_o.len_zero     = len_q == '0;
    sts_o.span_over    = span_need > span_lim;
    sts_o.partial      = seg != psz;
    sts_o.final_seg    = fits_page;
  end

  // Result beat selection
  always_comb begin
    res_d = '0;
    case (cmd_i.emit_sel)
      fcs_pkg::EMIT_FLAG: begin
        res_d.command_kind = fcs_pkg::KIND_NONE;
        res_d.status       = cmd_i.status;
        res_d.last         = 1'b1;
      end
      fcs_pkg::EMIT_LOAD: begin
        res_d.command_kind   = fcs_pkg::KIND_LOAD;
        res_d.device_address = addr_page;
        res_d.page_index     = page_q[fcs_pkg::PAGE_IDX_W-1:0];
        res_d.status         = fcs_pkg::STAT_OK;
      end
      fcs_pkg::EMIT_MAIN: begin
        res_d.page_index = page_q[fcs_pkg::PAGE_IDX_W-1:0];
        res_d.status     = fcs_pkg::STAT_OK;
        res_d.last       = fits_page;
        case (op_q)
          fcs_pkg::OP_READ: begin
            res_d.command_kind   = fcs_pkg::KIND_READ;
            res_d.device_address = addr_main;
            res_d.segment_bytes  = seg;
          end
          fcs_pkg::OP_WRITE: begin
            res_d.command_kind   = fcs_pkg::KIND_PROGRAM;
            res_d.device_address = addr_main;
            res_d.segment_bytes  = seg;
          end
          fcs_pkg::OP_ERASE: begin
            res_d.command_kind   = fcs_pkg::KIND_ERASE;
            res_d.device_address = addr_page;
          end
          default: begin
            res_d.command_kind = fcs_pkg::KIND_NONE;
          end
        endcase
      end
      default: begin
        res_d.command_kind = fcs_pkg::KIND_NONE;
        res_d.last         = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= req_i.operation;
      start_q     <= req_i.start_address;
      len_q       <= req_i.byte_length;
      remaining_q <= req_i.byte_length;
    end else if (cmd_i.step) begin
      remaining_q <= remaining_q - fcs_pkg::LEN_W'(seg);
    end
    if (cmd_i.take_page) begin
      page_q   <= div_quo;
      offset_q <= div_rem;
    end else if (cmd_i.step) begin
      page_q   <= page_q + 1'b1;
      offset_q <= '0;
    end
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire

// ===== design/fcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcs_ctrl: request sequencer
// Steps each request through its checks, the divisions and the per-page
// result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module fcs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  fcs_pkg::sts_t  sts_i,
  output fcs_pkg::cmd_t  cmd_o,
  output logic           busy_o
);

  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE    = 3'd0;
  localparam logic [ST_W-1:0] S_CHECK   = 3'd1;
  localparam logic [ST_W-1:0] S_DIV_ST  = 3'd2;
  localparam logic [ST_W-1:0] S_DIV_LEN = 3'd3;
  localparam logic [ST_W-1:0] S_SPAN    = 3'd4;
  localparam logic [ST_W-1:0] S_EMIT    = 3'd5;

  logic [ST_W-1:0] state_q, state_d;
  logic            loaded_q, loaded_d;

  always_comb begin
    state_d  = state_q;
    loaded_d = loaded_q;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.empty_req) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = fcs_pkg::EMIT_FLAG;
          cmd_o.status   = fcs_pkg::STAT_OK;
          state_d        = S_IDLE;
        end else if (sts_i.over_chip) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = fcs_pkg::EMIT_FLAG;
          cmd_o.status   = fcs_pkg::STAT_BEYOND;
          state_d        = S_IDLE;
        end else begin
          cmd_o.div_go = 1'b1;
          state_d      = S_DIV_ST;
        end
      end
      S_DIV_ST: begin
        if (sts_i.div_done) begin
          cmd_o.take_page = 1'b1;
          if (sts_i.is_erase) begin
            cmd_o.div_go  = 1'b1;
            cmd_o.div_len = 1'b1;
            state_d       = S_DIV_LEN;
          end else begin
            state_d = S_SPAN;
          end
        end
      end
      S_DIV_LEN: begin
        cmd_o.div_len = 1'b1;
        if (sts_i.div_done) begin
          if (!sts_i.off_zero || !sts_i.div_rem_zero) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = fcs_pkg::EMIT_FLAG;
            cmd_o.status   = fcs_pkg::STAT_MISALIGN;
            state_d        = S_IDLE;
          end else if (sts_i.len_zero) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = fcs_pkg::EMIT_FLAG;
            cmd_o.status   = fcs_pkg::STAT_OK;
            state_d        = S_IDLE;
          end else begin
            state_d = S_SPAN;
          end
        end
      end
      S_SPAN: begin
        loaded_d = 1'b0;
        if (sts_i.span_over) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = fcs_pkg::EMIT_FLAG;
          cmd_o.status   = fcs_pkg::STAT_SPAN;
          state_d        = S_IDLE;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.is_write && sts_i.partial && !loaded_q) begin
          // partial page write: fetch the page into the buffer first
          cmd_o.emit_sel = fcs_pkg::EMIT_LOAD;
          loaded_d       = 1'b1;
        end else begin
          cmd_o.emit_sel = fcs_pkg::EMIT_MAIN;
          cmd_o.step     = 1'b1;
          loaded_d       = 1'b0;
          if (sts_i.final_seg) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      loaded_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

`default_nettype wire

// ===== design/page_flash_command_splitter.sv =====
// ----------------------------------------------------------------------------
// page_flash_command_splitter: per-page flash command sequencer
// Splits read, write and erase requests into page-sized flash command beats.
// ----------------------------------------------------------------------------
// Pulse start with a request while busy is low; the request is taken at that
// edge. Result beats then appear on result_o, one per cycle at most, each
// marked by a single-cycle result_strobe_o. There is no back-pressure: capture
// every strobed beat, since nothing holds it. The beat with last set closes
// the request. Each request is checked first, after which an empty request or
// a beyond-chip error shows its single beat in the next cycle. Otherwise the
// start address is divided by the page size, giving 24 quotient bits and a
// remainder; an erase then also divides the length. Then comes the span
// check, then one beat per cycle, and a partial-page write spends one extra
// beat loading the page into the buffer. busy falls with the last beat being
// registered, so the next request can be taken in the cycle that beat is
// shown. Configure page_bytes, page_shift and chip_bytes over the APB port
// (byte addresses 0x0, 0x4, 0x8) only while busy is low and no beat is
// pending.
// ----------------------------------------------------------------------------
`default_nettype none

module page_flash_command_splitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          start,
  output logic                          busy,
  input  fcs_pkg::req_t                 request_i,
  // result side
  output logic                          result_strobe_o,
  output fcs_pkg::res_t                 result_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcs_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [fcs_pkg::PSZ_W-1:0]     page_bytes_q;
  logic [fcs_pkg::SHIFT_W-1:0]   page_shift_q;
  logic [fcs_pkg::CHIP_W-1:0]    chip_bytes_q;
  logic                          cfg_wr;
  logic [fcs_pkg::REG_IDX_W-1:0] reg_idx;
  fcs_pkg::cfg_t                 cfg;
  fcs_pkg::cmd_t                 cmd;
  fcs_pkg::sts_t                 sts;

  // Register file: write on the access phase, reads are combinational
  assign pready  = 1'b1;
  assign reg_idx = paddr[fcs_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_bytes_q <= fcs_pkg::PAGE_BYTES_RST;
      page_shift_q <= fcs_pkg::PAGE_SHIFT_RST;
      chip_bytes_q <= fcs_pkg::CHIP_BYTES_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        fcs_pkg::REG_PAGE_BYTES: page_bytes_q <= pwdata[fcs_pkg::PSZ_W-1:0];
        fcs_pkg::REG_PAGE_SHIFT: page_shift_q <= pwdata[fcs_pkg::SHIFT_W-1:0];
        fcs_pkg::REG_CHIP_BYTES: chip_bytes_q <= pwdata[fcs_pkg::CHIP_W-1:0];
        default: begin
          // unmapped: drop the write
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fcs_pkg::REG_PAGE_BYTES: prdata = 32'(page_bytes_q);
      fcs_pkg::REG_PAGE_SHIFT: prdata = 32'(page_shift_q);
      fcs_pkg::REG_CHIP_BYTES: prdata = 32'(chip_bytes_q);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.page_bytes = page_bytes_q;
  assign cfg.page_shift = page_shift_q;
  assign cfg.chip_bytes = chip_bytes_q;

  // Sequencer: checks, divisions and per-page stepping
  fcs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Datapath: request hold, divider, address forming, result register
  fcs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .req_i        (request_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_strobe_o (result_strobe_o),
    .res_o        (result_o)
  );

endmodule

`default_nettype wire

// ===== tb/page_flash_command_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_flash_command_checker: result predictor and scoreboard
// Watches the request, result and register channels of the splitter, works
// out the command beats of every request taken and compares them in order.
// ----------------------------------------------------------------------------

module page_flash_command_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  fcs_pkg::req_t               request_i,
  input  logic                        result_strobe_i,
  input  fcs_pkg::res_t               result_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [fcs_pkg::PADDR_W-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  output int                          fail_count_o,
  output int                          pending_beats_o,
  output int                          request_count_o,
  output int                          beat_count_o,
  output int                          error_beats_o
);

  import fcs_pkg::*;

  logic [PSZ_W-1:0]   page_bytes_q;
  logic [SHIFT_W-1:0] page_shift_q;
  logic [CHIP_W-1:0]  chip_bytes_q;

  res_t expected_beats[$];

  function automatic res_t make_beat(logic [KIND_W-1:0] kind, logic [ADDR_BITS-1:0] addr,
                                     logic [31:0] seg, logic [31:0] page,
                                     logic [STAT_W-1:0] status);
    res_t b;
    b.command_kind   = kind;
    b.device_address = addr;
    b.segment_bytes  = seg[SEG_W-1:0];
    b.page_index     = page[PAGE_IDX_W-1:0];
    b.status         = status;
    b.last           = 1'b0;
    return b;
  endfunction

  function automatic logic [ADDR_BITS-1:0] flash_address(logic [31:0] page,
                                                         logic [31:0] offset);
    logic [63:0] wide;
    wide = (64'(page[ADDR_BITS-1:0]) << page_shift_q) + 64'(offset);
    return wide[ADDR_BITS-1:0];
  endfunction

  // Queue the beats one request gives under the current register values.
  function automatic void expand_request(req_t req);
    res_t        beats[$];
    res_t        closing;
    logic [31:0] psz, first, len, span, page, offset, remaining, seg;
    psz   = (page_bytes_q == '0) ? 32'd1 :
            (page_bytes_q > PSZ_MAX) ? 32'(PSZ_MAX) : 32'(page_bytes_q);
    first = 32'(req.start_address);
    len   = 32'(req.byte_length);
    if (req.operation == OP_UNUSED || (len == 0 && req.operation != OP_ERASE)) begin
      beats.push_back(make_beat(KIND_NONE, '0, 0, 0, STAT_OK));
    end else if (first + len > 32'(chip_bytes_q)) begin
      beats.push_back(make_beat(KIND_NONE, '0, 0, 0, STAT_BEYOND));
    end else if (req.operation == OP_ERASE && ((first % psz) != 0 || (len % psz) != 0)) begin
      beats.push_back(make_beat(KIND_NONE, '0, 0, 0, STAT_MISALIGN));
    end else if (len == 0) begin
      beats.push_back(make_beat(KIND_NONE, '0, 0, 0, STAT_OK));
    end else begin
      span = (first + len - 1) / psz - first / psz + 1;
      if (span > MAX_SPAN_PAGES) begin
        beats.push_back(make_beat(KIND_NONE, '0, 0, 0, STAT_SPAN));
      end else begin
        page      = first / psz;
        offset    = first % psz;
        remaining = len;
        while (remaining > 0) begin
          seg = psz - offset;
          if (seg > remaining) seg = remaining;
          case (req.operation)
            OP_READ: begin
              beats.push_back(make_beat(KIND_READ, flash_address(page, offset), seg, page,
                                        STAT_OK));
            end
            OP_WRITE: begin
              // a part page needs the page in the buffer first
              if (seg != psz)
                beats.push_back(make_beat(KIND_LOAD, flash_address(page, 0) & ~ADDR_LOW_MASK,
                                          0, page, STAT_OK));
              beats.push_back(make_beat(KIND_PROGRAM, flash_address(page, offset), seg,
                                        page, STAT_OK));
            end
            default: begin
              beats.push_back(make_beat(KIND_ERASE, flash_address(page, 0) & ~ADDR_LOW_MASK,
                                        0, page, STAT_OK));
            end
          endcase
          remaining = remaining - seg;
          offset    = 0;
          page      = page + 1;
        end
      end
    end
    closing      = beats.pop_back();
    closing.last = 1'b1;
    beats.push_back(closing);
    foreach (beats[i]) expected_beats.push_back(beats[i]);
  endfunction

  function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (got === want) return 1'b1;
    $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t want;
    bit   ok;
    if (!rst_ni) begin
      page_bytes_q = PAGE_BYTES_RST;
      page_shift_q = PAGE_SHIFT_RST;
      chip_bytes_q = CHIP_BYTES_RST;
      expected_beats.delete();
      fail_count_o    = 0;
      pending_beats_o = 0;
      request_count_o = 0;
      beat_count_o    = 0;
      error_beats_o   = 0;
    end else begin
      // a beat shown at this edge always belongs to an older request
      if (result_strobe_i) begin
        beat_count_o++;
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: 0x%0h", result_i);
          fail_count_o++;
        end else begin
          want = expected_beats.pop_front();
          ok   = 1'b1;
          ok  &= field_ok("command_kind", 32'(want.command_kind), 32'(result_i.command_kind));
          ok  &= field_ok("device_address", 32'(want.device_address),
                          32'(result_i.device_address));
          ok  &= field_ok("segment_bytes", 32'(want.segment_bytes),
                          32'(result_i.segment_bytes));
          ok  &= field_ok("page_index", 32'(want.page_index), 32'(result_i.page_index));
          ok  &= field_ok("status", 32'(want.status), 32'(result_i.status));
          ok  &= field_ok("last", 32'(want.last), 32'(result_i.last));
          if (!ok) fail_count_o++;
          if (want.status != STAT_OK) error_beats_o++;
        end
      end
      if (start_i && !busy_i) begin
        request_count_o++;
        expand_request(request_i);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_PAGE_BYTES: page_bytes_q = pwdata_i[PSZ_W-1:0];
          REG_PAGE_SHIFT: page_shift_q = pwdata_i[SHIFT_W-1:0];
          REG_CHIP_BYTES: chip_bytes_q = pwdata_i[CHIP_W-1:0];
          default: ;
        endcase
      end
      pending_beats_o = expected_beats.size();
    end
  end

endmodule

// ===== tb/tb_page_flash_command_splitter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_flash_command_splitter: top of the splitter testbench
// Drives requests and register writes, lets the checker predict and compare
// every command beat, and gives the verdict at the end of the run.
// ----------------------------------------------------------------------------

module tb_page_flash_command_splitter;

  import fcs_pkg::*;

  // Phases of the random part: register values, sender idling and size.
  // Page size 0 and 4095 exercise the clamping to 1 and 2048; chip size 0
  // turns every real request into a beyond-chip error.
  localparam int NUM_PHASES = 8;
  localparam int TAIL_CYCLES = 150;  // division of address and length, then at most 34 beats

  int unsigned phase_psz   [NUM_PHASES] = '{528, 1, 2048, 0, 4095, 256, 1000, 0};
  int unsigned phase_shift [NUM_PHASES] = '{10, 0, 15, 1, 11, 8, 12, 0};
  int unsigned phase_chip  [NUM_PHASES] = '{2162688, 16777216, 16777216, 4096, 0,
                                            1048576, 12345678, 0};
  int unsigned phase_items [NUM_PHASES] = '{60, 50, 50, 40, 30, 50, 50, 40};
  int unsigned phase_idle  [NUM_PHASES] = '{0, 81, 0, 33, 81, 33, 0, 81};

  logic clk_i = 1'b0;
  logic rst_ni;

  logic        start;
  logic        busy;
  req_t        request;
  logic        result_strobe;
  res_t        result;
  logic        psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending_beats, request_count, beat_count, error_beats;

  // Register values as last written, used only to shape the stimulus.
  int unsigned cur_psz, cur_chip;
  int unsigned idle_pct;
  int unsigned settings_used;

  always #5 clk_i = ~clk_i;

  page_flash_command_splitter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .request_i       (request),
    .result_strobe_o (result_strobe),
    .result_o        (result),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  page_flash_command_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .request_i       (request),
    .result_strobe_i (result_strobe),
    .result_i        (result),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .fail_count_o    (fail_count),
    .pending_beats_o (pending_beats),
    .request_count_o (request_count),
    .beat_count_o    (beat_count),
    .error_beats_o   (error_beats)
  );

  function automatic int unsigned effective_page(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > 2048) return 2048;
    return raw;
  endfunction

  function automatic req_t make_request(logic [OP_W-1:0] op, int unsigned first,
                                        int unsigned len);
    req_t r;
    r.operation     = op;
    r.start_address = LEN_W'(first);
    r.byte_length   = LEN_W'(len);
    return r;
  endfunction

  // Mostly well-formed requests sized to the current page and chip, so that
  // the splitting loop is reached; the rest is raw noise, half with a short length.
  function automatic req_t random_request();
    req_t        r;
    int unsigned psz, pages, roll, first, len, top_page;
    psz  = effective_page(cur_psz);
    roll = $urandom_range(99);
    if (roll < 10) begin
      r.operation     = OP_W'($urandom);
      r.start_address = LEN_W'($urandom);
      r.byte_length   = (roll < 5) ? LEN_W'($urandom) : LEN_W'($urandom_range(64));
      return r;
    end
    roll = $urandom_range(99);
    r.operation = (roll < 5) ? OP_UNUSED : (roll < 40) ? OP_READ :
                  (roll < 72) ? OP_WRITE : OP_ERASE;
    // now and then go past the span limit
    pages = ($urandom_range(19) == 0) ? $urandom_range(33, 34) : $urandom_range(1, 32);
    if (r.operation == OP_ERASE) begin
      top_page = cur_chip / psz;
      first    = ((top_page > pages) ? $urandom_range(top_page - pages) : 0) * psz;
      len      = pages * psz;
      roll     = $urandom_range(99);
      if (psz > 1 && roll < 6) first = first + $urandom_range(1, psz - 1);
      else if (psz > 1 && roll < 12) len = len - $urandom_range(1, psz - 1);
      else if (roll < 15) len = 0;
    end else begin
      first = (cur_chip > 0) ? $urandom_range(cur_chip - 1) : $urandom_range(24'hFF_FFFF);
      len   = ($urandom_range(1) == 1) ? $urandom_range(1, psz) : $urandom_range(1, pages * psz);
      if ($urandom_range(29) == 0) len = 0;
      else if (first + len > cur_chip && cur_chip > first && $urandom_range(9) != 0)
        len = cur_chip - first;  // pull most requests back inside the chip
    end
    r.start_address = LEN_W'(first);
    r.byte_length   = LEN_W'(len);
    return r;
  endfunction

  // Hold start with the request until the splitter takes it.
  task automatic send_request(req_t r);
    @(negedge clk_i);
    start   <= 1'b1;
    request <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Drop start and wait until every expected beat has come and busy is low.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_beats != 0 || busy !== 1'b0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [REG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(int unsigned psz, int unsigned shift, int unsigned chip);
    apb_write(REG_PAGE_BYTES, psz);
    apb_write(REG_PAGE_SHIFT, shift);
    apb_write(REG_CHIP_BYTES, chip);
    cur_psz   = psz;
    cur_chip  = chip;
    settings_used++;
  endtask

  // Directed requests under the reset page geometry (528-byte pages).
  task automatic run_directed();
    send_request(make_request(OP_READ, 0, 1));
    send_request(make_request(OP_READ, 0, 528));
    send_request(make_request(OP_READ, 500, 100));           // crosses one boundary
    send_request(make_request(OP_WRITE, 0, 528));            // whole page, no load
    send_request(make_request(OP_WRITE, 10, 20));            // part page
    send_request(make_request(OP_WRITE, 520, 1100));         // part, two whole, part
    send_request(make_request(OP_ERASE, 0, 528));
    send_request(make_request(OP_ERASE, 3 * 528, 4 * 528));
    send_request(make_request(OP_ERASE, 1, 528));            // start misaligned
    send_request(make_request(OP_ERASE, 0, 100));            // length misaligned
    send_request(make_request(OP_ERASE, 0, 0));              // empty erase
    send_request(make_request(OP_ERASE, 1, 0));              // empty but misaligned
    send_request(make_request(OP_READ, 24'hFF_FFFF, 0));     // empty read
    send_request(make_request(OP_WRITE, 12345, 0));          // empty write
    send_request(make_request(OP_UNUSED, 0, 77));
    send_request(make_request(OP_READ, 2162687, 1));         // last byte of chip
    send_request(make_request(OP_READ, 2162687, 2));         // one past the end
    send_request(make_request(OP_READ, 24'hFF_FFFF, 24'hFF_FFFF));
    send_request(make_request(OP_READ, 0, 32 * 528));        // span limit exactly
    send_request(make_request(OP_READ, 1, 32 * 528));        // one page over
    send_request(make_request(OP_WRITE, 1, 32 * 528));
    send_request(make_request(OP_WRITE, 5, 31 * 528));       // loads at both ends
    send_request(make_request(OP_ERASE, 0, 32 * 528));
    send_request(make_request(OP_ERASE, 0, 33 * 528));
    send_request(make_request(OP_UNUSED, 24'hFF_FFFF, 24'hFF_FFFF));
  endtask

  // Stimulus: reset, directed requests, then the random phases; verdict at the end.
  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    request       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cur_psz       = PAGE_BYTES_RST;
    cur_chip      = CHIP_BYTES_RST;
    idle_pct      = 0;
    settings_used = 1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p == NUM_PHASES - 1)
        configure($urandom_range(1, 2048), $urandom_range(1, 15),
                  $urandom_range(4096, 16777216));
      else
        configure(phase_psz[p], phase_shift[p], phase_chip[p]);
      idle_pct = phase_idle[p];
      for (int n = 0; n < phase_items[p]; n++) begin
        idle_gap();
        // now and then hold off until the splitter has fully drained
        if ($urandom_range(99) < 3) drain();
        send_request(random_request());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Run covered %0d requests under %0d register settings, %0d beats checked,",
             request_count, settings_used, beat_count);
    $display("%0d of them error reports; page sizes 1 to 2048 with clamping, shifts 0 to 15.",
             error_beats);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("page_flash_command_splitter verification clean");
    end else begin
      $display("page_flash_command_splitter verification failed");
    end
    $finish;
  end

  // Guard the whole run: end it as failed if it has not finished by the timeout.
  initial begin
    #10_000_000;
    $display("Timed out with %0d beats still expected", pending_beats);
    $display("page_flash_command_splitter verification failed");
    $finish;
  end

endmodule
